// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_WR = 2'd1;
  localparam logic [1:0] FUNC_RD = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // byte_count value that marks the address byte after a repeated start
  localparam logic [7:0] BYTE_RD_ADDR = 8'd3;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_WR   = 2'd1,
    CMD_RD   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BUSY = 2'd1,
    STAT_ERR  = 2'd2,
    STAT_NACK = 2'd3
  } status_e;

  typedef enum logic [23:0] {
    PH_IDLE = 24'h000001,
    PH_ST0  = 24'h000002,
    PH_ST1  = 24'h000004,
    PH_ST2  = 24'h000008,
    PH_SD0  = 24'h000010,
    PH_SD1  = 24'h000020,
    PH_SD2  = 24'h000040,
    PH_WT0  = 24'h000080,
    PH_WT1  = 24'h000100,
    PH_WT2  = 24'h000200,
    PH_WT3  = 24'h000400,
    PH_RS0  = 24'h000800,
    PH_RS1  = 24'h001000,
    PH_RS2  = 24'h002000,
    PH_RV0  = 24'h004000,
    PH_RV1  = 24'h008000,
    PH_MK0  = 24'h010000,
    PH_MK1  = 24'h020000,
    PH_MK2  = 24'h040000,
    PH_MK3  = 24'h080000,
    PH_SP0  = 24'h100000,
    PH_SP1  = 24'h200000,
    PH_SP2  = 24'h400000,
    PH_SP3  = 24'h800000
  } phase_e;

  // classified slot as it sits in the queue
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] len;
    logic       sda;
  } slot_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== design/i2cm_chan_if.sv =====
// Valid/ready channel interfaces for slot beats in and result beats out.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic [7:0] read_len;
  logic       sda_in;

  modport source (output valid, func, dev_addr, reg_addr, wr_data, read_len, sda_in,
                  input ready);
  modport sink (input valid, func, dev_addr, reg_addr, wr_data, read_len, sda_in,
                output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] rd_byte;
  logic       rd_valid;
  logic       rd_last;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_level, sda_level, rd_byte, rd_valid, rd_last,
                  busy_res, done_res, status, input ready);
  modport sink (input valid, scl_level, sda_level, rd_byte, rd_valid, rd_last,
                busy_res, done_res, status, output ready);
endinterface

// ===== design/i2cm_front.sv =====
// Front end: takes slot beats and classifies the command they carry.
module i2cm_front (
  i2cm_in_if.sink        cmd_i,
  output logic           push_valid_o,
  output i2cm_pkg::slot_t push_slot_o,
  input  logic           push_ready_i
);
  import i2cm_pkg::*;

  cmd_e kind;

  always_comb begin
    case (cmd_i.func)
      FUNC_WR: kind = CMD_WR;
      FUNC_RD: kind = CMD_RD;
      default: kind = CMD_NONE;
    endcase
  end

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;

  always_comb begin
    push_slot_o.kind     = kind;
    push_slot_o.dev_addr = cmd_i.dev_addr;
    push_slot_o.reg_addr = cmd_i.reg_addr;
    push_slot_o.wr_data  = cmd_i.wr_data;
    // zero length reads one byte
    push_slot_o.len      = (cmd_i.read_len == 8'd0) ? 8'd1 : cmd_i.read_len;
    push_slot_o.sda      = cmd_i.sda_in;
  end

endmodule

// ===== design/i2cm_fifo.sv =====
// Short queue of classified slots between front and back end.
module i2cm_fifo #(
  parameter int unsigned Depth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  i2cm_pkg::slot_t push_slot_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output i2cm_pkg::slot_t pop_slot_o,
  input  logic            pop_ready_i
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  slot_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_slot_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_slot_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue pointers apart");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == FullCnt && !pop) |=> $stable(wr_ptr_q)) else $error("write into full queue");

endmodule

// ===== design/i2cm_back.sv =====
// Back end: bus phase sequencer, counters, shift register and result register.
module i2cm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  i2cm_pkg::slot_t pop_slot_i,
  output logic            pop_ready_o,
  i2cm_out_if.source      res_o
);
  import i2cm_pkg::*;

  phase_e     phase_q, phase_d, cur;
  logic [3:0] bit_q, bit_d, nbit;
  logic [7:0] byte_q, byte_d, nbyte;
  logic [7:0] shift_q, shift_d, nshift;
  logic [7:0] dev_q, dev_d, reg_q, reg_d, wdat_q, wdat_d, len_q, len_d;
  logic       op_q, op_d;
  logic       scl_q, scl_d, sda_q, sda_d;
  res_t       res_q, res_d;
  logic       res_valid_q;
  logic       step;

  assign step        = pop_valid_i && (!res_valid_q || res_o.ready);
  assign pop_ready_o = step;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    wdat_d  = wdat_q;
    len_d   = len_q;
    op_d    = op_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    res_d   = '0;
    res_d.busy_res = 1'b1;
    cur     = phase_q;
    nbit    = bit_q + 4'd1;
    nbyte   = byte_q + 8'd1;
    nshift  = {shift_q[6:0], pop_slot_i.sda};

    if (phase_q == PH_IDLE) begin
      if (pop_slot_i.kind != CMD_NONE) begin
        dev_d   = pop_slot_i.dev_addr;
        reg_d   = pop_slot_i.reg_addr;
        wdat_d  = pop_slot_i.wr_data;
        len_d   = pop_slot_i.len;
        op_d    = (pop_slot_i.kind == CMD_RD);
        byte_d  = '0;
        bit_d   = '0;
        shift_d = '0;
        cur     = PH_ST0;
      end else begin
        res_d.busy_res = 1'b0;
      end
    end

    case (cur)
      PH_ST0, PH_RS0: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        if (cur == PH_ST0 && !pop_slot_i.sda) begin
          res_d.done_res = 1'b1;
          res_d.status   = STAT_BUSY;
          phase_d        = PH_IDLE;
        end else begin
          phase_d = (cur == PH_ST0) ? PH_ST1 : PH_RS1;
        end
      end
      PH_ST1, PH_RS1: begin
        scl_d = 1'b1;
        sda_d = 1'b0;
        if (cur == PH_ST1 && pop_slot_i.sda) begin
          res_d.done_res = 1'b1;
          res_d.status   = STAT_ERR;
          phase_d        = PH_IDLE;
        end else begin
          phase_d = (cur == PH_ST1) ? PH_ST2 : PH_RS2;
        end
      end
      PH_ST2: begin
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        byte_d  = '0;
        shift_d = dev_q;
        bit_d   = '0;
        phase_d = PH_SD0;
      end
      PH_RS2: begin
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        byte_d  = BYTE_RD_ADDR;
        shift_d = dev_q + 8'd1;
        bit_d   = '0;
        phase_d = PH_SD0;
      end
      PH_SD0: begin
        scl_d   = 1'b0;
        phase_d = PH_SD1;
      end
      PH_SD1: begin
        scl_d   = 1'b0;
        sda_d   = shift_q[7];
        shift_d = {shift_q[6:0], 1'b0};
        phase_d = PH_SD2;
      end
      PH_SD2: begin
        scl_d = 1'b1;
        if (nbit >= BITS_PER_BYTE) begin
          bit_d   = '0;
          phase_d = PH_WT0;
        end else begin
          bit_d   = nbit;
          phase_d = PH_SD0;
        end
      end
      PH_WT0: begin
        scl_d   = 1'b0;
        phase_d = PH_WT1;
      end
      PH_WT1: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        phase_d = PH_WT2;
      end
      PH_WT2: begin
        scl_d = 1'b1;
        // only the device address ack counts; bit_count flags the nack
        if (byte_q == '0 && pop_slot_i.sda) begin
          bit_d = 4'd1;
        end
        phase_d = PH_WT3;
      end
      PH_WT3: begin
        scl_d = 1'b0;
        if (bit_q == 4'd1) begin
          phase_d = PH_SP0;
        end else if (byte_q == 8'd0) begin
          byte_d  = 8'd1;
          shift_d = reg_q;
          bit_d   = '0;
          phase_d = PH_SD0;
        end else if (byte_q == 8'd1) begin
          byte_d = 8'd2;
          if (op_q) begin
            phase_d = PH_RS0;
          end else begin
            shift_d = wdat_q;
            bit_d   = '0;
            phase_d = PH_SD0;
          end
        end else if (byte_q == 8'd2) begin
          bit_d   = '0;
          phase_d = PH_SP0;
        end else begin
          byte_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          phase_d = PH_RV0;
        end
      end
      PH_RV0: begin
        sda_d   = 1'b1;
        scl_d   = 1'b0;
        phase_d = PH_RV1;
      end
      PH_RV1: begin
        sda_d   = 1'b1;
        scl_d   = 1'b1;
        shift_d = nshift;
        if (nbit >= BITS_PER_BYTE) begin
          bit_d          = '0;
          res_d.rd_byte  = nshift;
          res_d.rd_valid = 1'b1;
          res_d.rd_last  = ({1'b0, byte_q} + 9'd1) == {1'b0, len_q};
          phase_d        = PH_MK0;
        end else begin
          bit_d   = nbit;
          phase_d = PH_RV0;
        end
      end
      PH_MK0: begin
        scl_d   = 1'b0;
        phase_d = PH_MK1;
      end
      PH_MK1: begin
        scl_d   = 1'b0;
        // nack after the last byte
        sda_d   = ({1'b0, byte_q} + 9'd1) >= {1'b0, len_q};
        phase_d = PH_MK2;
      end
      PH_MK2: begin
        scl_d   = 1'b1;
        phase_d = PH_MK3;
      end
      PH_MK3: begin
        scl_d   = 1'b0;
        byte_d  = nbyte;
        shift_d = '0;
        if (nbyte >= len_q) begin
          bit_d   = '0;
          phase_d = PH_SP0;
        end else begin
          phase_d = PH_RV0;
        end
      end
      PH_SP0: begin
        scl_d   = 1'b0;
        phase_d = PH_SP1;
      end
      PH_SP1: begin
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        phase_d = PH_SP2;
      end
      PH_SP2: begin
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        phase_d = PH_SP3;
      end
      PH_SP3: begin
        scl_d          = 1'b1;
        sda_d          = 1'b1;
        res_d.done_res = 1'b1;
        res_d.status   = (bit_q == 4'd1) ? STAT_NACK : STAT_OK;
        bit_d          = '0;
        phase_d        = PH_IDLE;
      end
      default: begin
      end
    endcase

    res_d.scl_level = scl_d;
    res_d.sda_level = sda_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      byte_q      <= '0;
      shift_q     <= '0;
      dev_q       <= '0;
      reg_q       <= '0;
      wdat_q      <= '0;
      len_q       <= '0;
      op_q        <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
        byte_q  <= byte_d;
        shift_q <= shift_d;
        dev_q   <= dev_d;
        reg_q   <= reg_d;
        wdat_q  <= wdat_d;
        len_q   <= len_d;
        op_q    <= op_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.scl_level = res_q.scl_level;
  assign res_o.sda_level = res_q.sda_level;
  assign res_o.rd_byte   = res_q.rd_byte;
  assign res_o.rd_valid  = res_q.rd_valid;
  assign res_o.rd_last   = res_q.rd_last;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.status    = res_q.status;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_d.done_res) |=> (phase_q == PH_IDLE)) else $error("done without idle");
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.done_res) |-> (res_q.status == STAT_OK))
    else $error("status outside done beat");
  a_rd_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.rd_valid) |-> (res_q.busy_res && op_q))
    else $error("read byte outside read command");

endmodule

// ===== design/i2c_master_register_access_unit.sv =====
// I2C register access master: top level joining front end, slot queue and back end.
// One slot beat in gives one result beat out, one beat per clock sustained while the
// result receiver keeps ready high. A beat lands in the slot queue at the edge it is
// taken; the back end then pops it and registers its result in the output register.
// The back-end sequencer advances one bus phase per slot; the queue lets the front
// keep taking slots while a result waits at the output.
module i2c_master_register_access_unit #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_in_if.sink     cmd_i,
  i2cm_out_if.source  res_o
);
  import i2cm_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  slot_t push_slot, pop_slot;

  i2cm_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_slot_o  (push_slot),
    .push_ready_i (push_ready)
  );

  i2cm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_slot_i  (push_slot),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_slot_o   (pop_slot),
    .pop_ready_i  (pop_ready)
  );

  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_slot_i  (pop_slot),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the I2C register access master: slot stream in, bus drives out.
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 600_000;
  localparam int N_SLOTS      = 1950;
  localparam int ACK_SLOT     = 29;   // slot of a command where the device address ACK is sampled

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] read_len;
    logic       sda_in;
  } slot_beat_t;

  typedef enum int { RUN_CLEAN, RUN_BUSY, RUN_BUSERR, RUN_NACK, RUN_NOISE } run_e;
  typedef enum int { FILL_RAND, FILL_ONES, FILL_ZEROS } fill_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2cm_in_if  cmd_if ();
  i2cm_out_if res_if ();

  i2c_master_register_access_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  slot_beat_t slot_q[$];
  res_t       line_res_q[$];

  int errors;
  int n_cmds;
  int drain_at;
  int n_sent;
  int burst_left;
  int gap_left;
  int n_checked;
  int n_rd_bytes;
  int n_status[4];

  // bus sequencer shadow state
  phase_e     line_phase;
  logic [3:0] bit_idx;
  logic [7:0] byte_idx;
  logic [7:0] shreg;
  logic [7:0] dev_q;
  logic [7:0] reg_q;
  logic [7:0] data_q;
  logic [7:0] len_q;
  logic       is_read;
  logic       scl_q;
  logic       sda_q;

  function automatic void start_byte(logic [7:0] b);
    shreg      = b;
    bit_idx    = '0;
    line_phase = PH_SD0;
  endfunction

  // bus drives and read data for one delay slot
  function automatic res_t drive_slot(slot_beat_t s);
    res_t   r;
    phase_e ph;
    r          = '0;
    r.busy_res = 1'b1;
    ph         = line_phase;
    if (ph == PH_IDLE) begin
      if (s.func == FUNC_WR || s.func == FUNC_RD) begin
        dev_q    = s.dev_addr;
        reg_q    = s.reg_addr;
        data_q   = s.wr_data;
        len_q    = (s.read_len == 8'd0) ? 8'd1 : s.read_len;
        is_read  = (s.func == FUNC_RD);
        byte_idx = '0;
        bit_idx  = '0;
        shreg    = '0;
        ph       = PH_ST0;
      end else begin
        r.busy_res = 1'b0;
      end
    end
    case (ph)
      PH_ST0, PH_RS0: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        if (ph == PH_ST0 && !s.sda_in) begin
          r.done_res = 1'b1;
          r.status   = STAT_BUSY;
          line_phase = PH_IDLE;
        end else begin
          line_phase = (ph == PH_ST0) ? PH_ST1 : PH_RS1;
        end
      end
      PH_ST1, PH_RS1: begin
        scl_q = 1'b1;
        sda_q = 1'b0;
        if (ph == PH_ST1 && s.sda_in) begin
          r.done_res = 1'b1;
          r.status   = STAT_ERR;
          line_phase = PH_IDLE;
        end else begin
          line_phase = (ph == PH_ST1) ? PH_ST2 : PH_RS2;
        end
      end
      PH_ST2: begin
        scl_q    = 1'b1;
        sda_q    = 1'b0;
        byte_idx = '0;
        start_byte(dev_q);
      end
      PH_RS2: begin
        scl_q    = 1'b1;
        sda_q    = 1'b0;
        byte_idx = BYTE_RD_ADDR;
        start_byte(dev_q + 8'd1);
      end
      PH_SD0: begin
        scl_q      = 1'b0;
        line_phase = PH_SD1;
      end
      PH_SD1: begin
        scl_q      = 1'b0;
        sda_q      = shreg[7];
        shreg      = {shreg[6:0], 1'b0};
        line_phase = PH_SD2;
      end
      PH_SD2: begin
        scl_q   = 1'b1;
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= BITS_PER_BYTE) begin
          bit_idx    = '0;
          line_phase = PH_WT0;
        end else begin
          line_phase = PH_SD0;
        end
      end
      PH_WT0: begin
        scl_q      = 1'b0;
        line_phase = PH_WT1;
      end
      PH_WT1: begin
        scl_q      = 1'b0;
        sda_q      = 1'b1;
        line_phase = PH_WT2;
      end
      PH_WT2: begin
        scl_q = 1'b1;
        // only the first address byte can abort; bit_idx carries the nack flag
        if (byte_idx == 8'd0 && s.sda_in) bit_idx = 4'd1;
        line_phase = PH_WT3;
      end
      PH_WT3: begin
        scl_q = 1'b0;
        if (bit_idx == 4'd1) begin
          line_phase = PH_SP0;
        end else if (byte_idx == 8'd0) begin
          byte_idx = 8'd1;
          start_byte(reg_q);
        end else if (byte_idx == 8'd1) begin
          byte_idx = 8'd2;
          if (is_read) line_phase = PH_RS0;
          else start_byte(data_q);
        end else if (byte_idx == 8'd2) begin
          bit_idx    = '0;
          line_phase = PH_SP0;
        end else begin
          byte_idx   = '0;
          bit_idx    = '0;
          shreg      = '0;
          line_phase = PH_RV0;
        end
      end
      PH_RV0: begin
        sda_q      = 1'b1;
        scl_q      = 1'b0;
        line_phase = PH_RV1;
      end
      PH_RV1: begin
        sda_q   = 1'b1;
        scl_q   = 1'b1;
        shreg   = {shreg[6:0], s.sda_in};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= BITS_PER_BYTE) begin
          bit_idx    = '0;
          r.rd_byte  = shreg;
          r.rd_valid = 1'b1;
          r.rd_last  = ({1'b0, byte_idx} + 9'd1 == {1'b0, len_q});
          line_phase = PH_MK0;
        end else begin
          line_phase = PH_RV0;
        end
      end
      PH_MK0: begin
        scl_q      = 1'b0;
        line_phase = PH_MK1;
      end
      PH_MK1: begin
        scl_q      = 1'b0;
        sda_q      = ({1'b0, byte_idx} + 9'd1 >= {1'b0, len_q});  // nack on last byte
        line_phase = PH_MK2;
      end
      PH_MK2: begin
        scl_q      = 1'b1;
        line_phase = PH_MK3;
      end
      PH_MK3: begin
        scl_q    = 1'b0;
        byte_idx = byte_idx + 8'd1;
        shreg    = '0;
        if (byte_idx >= len_q) begin
          bit_idx    = '0;
          line_phase = PH_SP0;
        end else begin
          line_phase = PH_RV0;
        end
      end
      PH_SP0: begin
        scl_q      = 1'b0;
        line_phase = PH_SP1;
      end
      PH_SP1: begin
        scl_q      = 1'b0;
        sda_q      = 1'b0;
        line_phase = PH_SP2;
      end
      PH_SP2: begin
        scl_q      = 1'b1;
        sda_q      = 1'b0;
        line_phase = PH_SP3;
      end
      PH_SP3: begin
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        r.done_res = 1'b1;
        r.status   = (bit_idx == 4'd1) ? STAT_NACK : STAT_OK;
        bit_idx    = '0;
        line_phase = PH_IDLE;
      end
      default: ;
    endcase
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    return r;
  endfunction

  // one command followed by exactly the slots it keeps the bus busy for, unless RUN_NOISE ends it early
  task automatic queue_command(logic [1:0] func, logic [7:0] dev, logic [7:0] ra,
                               logic [7:0] wd, logic [7:0] len, run_e how, fill_e fill);
    int         n;
    int         eff;
    slot_beat_t b;
    eff = (len == 8'd0) ? 1 : int'(len);
    case (how)
      RUN_BUSY:   n = 1;
      RUN_BUSERR: n = 2;
      RUN_NACK:   n = 35;
      default:    n = (func == FUNC_RD) ? 94 + 20 * eff : 91;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = '{func, dev, ra, wd, len, 1'b0};
      end else begin
        // stray commands while busy must be ignored
        b.func     = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : CMD_NONE;
        b.dev_addr = 8'($urandom);
        b.reg_addr = 8'($urandom);
        b.wr_data  = 8'($urandom);
        b.read_len = 8'($urandom);
      end
      case (fill)
        FILL_ONES:  b.sda_in = 1'b1;
        FILL_ZEROS: b.sda_in = 1'b0;
        default:    b.sda_in = 1'($urandom_range(0, 1));
      endcase
      if (how != RUN_NOISE) begin
        if (i == 0) b.sda_in = (how != RUN_BUSY);
        else if (i == 1) b.sda_in = (how == RUN_BUSERR);
        else if (i == ACK_SLOT) b.sda_in = (how == RUN_NACK);
      end
      slot_q.push_back(b);
    end
    n_cmds++;
  endtask

  task automatic queue_idle(int n);
    slot_beat_t b;
    for (int i = 0; i < n; i++) begin
      b.func     = $urandom_range(0, 1) ? FUNC_SPARE : CMD_NONE;
      b.dev_addr = 8'($urandom);
      b.reg_addr = 8'($urandom);
      b.wr_data  = 8'($urandom);
      b.read_len = 8'($urandom);
      b.sda_in   = 1'($urandom_range(0, 1));
      slot_q.push_back(b);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // slot driver
  always @(posedge clk_i or negedge rst_ni) begin
    slot_beat_t cur;
    slot_beat_t nx;
    logic       nv;
    if (!rst_ni) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.func     <= CMD_NONE;
      cmd_if.dev_addr <= '0;
      cmd_if.reg_addr <= '0;
      cmd_if.wr_data  <= '0;
      cmd_if.read_len <= '0;
      cmd_if.sda_in   <= 1'b1;
      n_sent          <= 0;
      burst_left      <= 0;
      gap_left        <= 0;
      line_phase = PH_IDLE;
      bit_idx    = '0;
      byte_idx   = '0;
      shreg      = '0;
      dev_q      = '0;
      reg_q      = '0;
      data_q     = '0;
      len_q      = '0;
      is_read    = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        cur = '{cmd_if.func, cmd_if.dev_addr, cmd_if.reg_addr, cmd_if.wr_data,
                cmd_if.read_len, cmd_if.sda_in};
        line_res_q.push_back(drive_slot(cur));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        nv = 1'b0;
        nx = '0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (slot_q.size() != 0 &&
                     !(n_sent == drain_at && line_res_q.size() != 0)) begin
          nx = slot_q.pop_front();
          nv = 1'b1;
          n_sent <= n_sent + 1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left <= $urandom_range(100, 400);
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(1, 40);
              gap_left   <= $urandom_range(0, 6);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        cmd_if.valid <= nv;
        if (nv) begin
          cmd_if.func     <= nx.func;
          cmd_if.dev_addr <= nx.dev_addr;
          cmd_if.reg_addr <= nx.reg_addr;
          cmd_if.wr_data  <= nx.wr_data;
          cmd_if.read_len <= nx.read_len;
          cmd_if.sda_in   <= nx.sda_in;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  int stall_mode;
  int mode_left;
  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    logic nr;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_mode   <= 0;
      mode_left    <= 0;
      stall_left   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.scl_level, res_if.sda_level, res_if.rd_byte, res_if.rd_valid,
                res_if.rd_last, res_if.busy_res, res_if.done_res, res_if.status};
        if (line_res_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none actual %0h", $time, got);
          errors++;
        end else begin
          want = line_res_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("rd_byte", want.rd_byte, got.rd_byte);
          check_field("rd_valid", want.rd_valid, got.rd_valid);
          check_field("rd_last", want.rd_last, got.rd_last);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("status", want.status, got.status);
          n_checked++;
          if (want.rd_valid) n_rd_bytes++;
          if (want.done_res) n_status[want.status]++;
        end
      end
      nr = 1'b1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        1: nr = ($urandom_range(0, 3) != 0);
        2: begin
          if (stall_left != 0) begin
            nr = 1'b0;
            stall_left <= stall_left - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 8);
          end
        end
        default: ;
      endcase
      res_if.ready <= nr;
    end
  end

  initial begin
    int          base;
    int          pick;
    int          r;
    logic [1:0]  func;
    logic [7:0]  len;
    run_e        how;
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.func     = CMD_NONE;
    cmd_if.dev_addr = '0;
    cmd_if.reg_addr = '0;
    cmd_if.wr_data  = '0;
    cmd_if.read_len = '0;
    cmd_if.sda_in   = 1'b1;
    res_if.ready    = 1'b0;
    errors          = 0;
    n_cmds          = 0;
    n_checked       = 0;
    n_rd_bytes      = 0;
    n_status        = '{default: 0};

    // directed commands
    queue_idle(2);
    queue_command(FUNC_WR, 8'h00, 8'h00, 8'h00, 8'h01, RUN_CLEAN, FILL_ZEROS);
    queue_idle(1);
    queue_command(FUNC_WR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, RUN_CLEAN, FILL_ONES);
    queue_command(FUNC_RD, 8'hFE, 8'h80, 8'h00, 8'h01, RUN_CLEAN, FILL_ONES);
    queue_idle(2);
    // device address wraps on the repeated start, zero length reads one byte
    queue_command(FUNC_RD, 8'hFF, 8'h01, 8'hFF, 8'h00, RUN_CLEAN, FILL_ZEROS);
    queue_command(FUNC_RD, 8'hA0, 8'h10, 8'h5A, 8'h03, RUN_CLEAN, FILL_RAND);
    queue_idle(1);
    queue_command(FUNC_WR, 8'h42, 8'h24, 8'h99, 8'h02, RUN_BUSY, FILL_RAND);
    queue_idle(2);
    queue_command(FUNC_RD, 8'h42, 8'h24, 8'h99, 8'h02, RUN_BUSERR, FILL_RAND);
    queue_idle(3);  // idle slots drive random SDA until the next command
    queue_command(FUNC_RD, 8'h3C, 8'hC3, 8'h00, 8'h04, RUN_NACK, FILL_RAND);
    queue_command(FUNC_WR, 8'hC3, 8'h3C, 8'hAA, 8'h04, RUN_NACK, FILL_RAND);
    queue_idle(1);
    queue_command(FUNC_RD, 8'h77, 8'h88, 8'h11, 8'h02, RUN_NOISE, FILL_RAND);
    queue_idle(2);
    queue_command(FUNC_RD, 8'h55, 8'hAA, 8'h00, 8'h10, RUN_CLEAN, FILL_RAND);
    queue_idle(1);
    base     = slot_q.size();
    drain_at = base;

    // random commands, mostly well-formed
    while (slot_q.size() < N_SLOTS) begin
      pick = $urandom_range(0, 99);
      func = $urandom_range(0, 1) ? FUNC_RD : FUNC_WR;
      r    = $urandom_range(0, 99);
      if (r < 80) len = 8'($urandom_range(1, 4));
      else if (r < 97) len = 8'($urandom_range(5, 24));
      else len = 8'd0;
      if (pick < 72) how = RUN_CLEAN;
      else if (pick < 82) how = RUN_NACK;
      else if (pick < 87) how = RUN_BUSY;
      else if (pick < 92) how = RUN_BUSERR;
      else how = RUN_NOISE;
      queue_command(func, 8'($urandom), 8'($urandom), 8'($urandom), len, how, FILL_RAND);
      queue_idle($urandom_range(0, 4));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (slot_q.size() != 0) @(posedge clk_i);
    while (cmd_if.valid || line_res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d slot results over %0d commands, %0d bytes read", n_checked,
             n_cmds, n_rd_bytes);
    $display("Finished: ok %0d, bus busy %0d, bus error %0d, no ack %0d", n_status[0],
             n_status[1], n_status[2], n_status[3]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", line_res_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
